[hdl/bqtl_pkg.sv]
`timescale 1ns / 1ps
package bqtl_pkg;

  localparam int NUM_PRED = 6;
  localparam int QW       = 24;

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [2:0] {
    CMD_LOOKUP    = 3'd0,
    CMD_WR_CUT    = 3'd1,
    CMD_WR_TABLE  = 3'd2,
    CMD_WR_THRESH = 3'd3,
    CMD_WR_RQUAL  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_MIN_QUAL  = 2'd1,
    REG_CUT_COUNT = 2'd2,
    REG_ROW_COUNT = 2'd3
  } reg_idx_t;

  localparam logic [29:0] CUT_COUNT_RESET = 30'd34636833;

  localparam q_t Q_MIN = 24'sh800000;
  localparam q_t Q_MAX = 24'sh7FFFFF;

  // Fold points in Q8.16.
  localparam int PEAK_P0 = 655;
  localparam int PEAK_P4 = 3932;
  localparam int KNEE_P4 = 26214;
  localparam int PEAK_P5 = -58982;

  // ceil(2^25 / 3): exact floor division by three for values below 2^24.
  localparam logic [23:0] RECIP3 = 24'hAAAAAB;

endpackage

[hdl/bqtl_ram.sv]
`timescale 1ns / 1ps
module bqtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/base_quality_table_lookup.sv]
`timescale 1ns / 1ps
// Base quality lookup. A command is taken on a clock edge with start high and
// busy low. Write commands (cut point, table byte, row threshold, row quality)
// complete in that cycle and produce no result; busy stays low. A lookup
// raises busy and, when done, presents out_quality and out_hit for exactly
// one cycle with out_valid high. The receiver cannot stall the block.
// A lookup first folds the predictors, and in row mode clamps them to the column
// maxima. In grid mode it then reads and compares each cut point in turn (the
// sum over the six predictors of their cut counts, up to 6*MAX_CUTS) and reads
// the table, giving no hit when the address lies past the table; in row mode it
// scans rows up to the first match, at most MAX_ROWS. Cut comparisons go one at
// a time through one compare unit fed by registered RAM reads; each row checks
// all six predictors at once. Only one lookup is in flight at a time.
// The configuration port writes mode, minimum quality, cut counts and row
// count when cfg_we is high. Use it only while idle; the block does not check.
// Synchronous reset initialises the sequencer, out_valid, config registers and
// column maxima; cut, table and row stores hold nothing defined until written.
module base_quality_table_lookup #(
  parameter int MAX_CUTS    = 16,
  parameter int TABLE_DEPTH = 65536,
  parameter int MAX_ROWS    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic signed [23:0] in_pred_0,
  input  logic signed [23:0] in_pred_1,
  input  logic signed [23:0] in_pred_2,
  input  logic signed [23:0] in_pred_3,
  input  logic signed [23:0] in_pred_4,
  input  logic signed [23:0] in_pred_5,
  input  logic [2:0]         in_column,
  input  logic [15:0]        in_address,
  input  logic signed [23:0] in_value,
  output logic               out_valid,
  output logic [7:0]         out_quality,
  output logic               out_hit,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [29:0]        cfg_data
);

  localparam int NP   = bqtl_pkg::NUM_PRED;
  localparam int CD   = NP * MAX_CUTS;
  localparam int CAW  = $clog2(CD);
  localparam int TAW  = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int RAW  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int JW   = $clog2(MAX_CUTS);
  localparam int NW   = $clog2(MAX_CUTS + 1);
  localparam int AW   = 30;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FOLD_A, ST_FOLD_B, ST_CLAMP, ST_CUT_RD, ST_CUT_CMP,
    ST_TBL_RD, ST_TBL_OUT, ST_ROW_RD, ST_ROW_CMP
  } state_t;

  state_t            state_r, state_nxt;
  bqtl_pkg::q_t      p_r [NP];
  bqtl_pkg::q_t      p_nxt [NP];
  bqtl_pkg::q_t      colmax_r [NP];
  bqtl_pkg::q_t      colmax_nxt [NP];
  logic [47:0]       prod_r, prod_nxt;
  logic              knee_r, knee_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [NW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     a_r, a_nxt;
  logic [RCW-1:0]    r_r, r_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_quality_r, out_quality_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              mode_r, mode_nxt;
  logic [7:0]        minq_r, minq_nxt;
  logic [29:0]       cutc_r, cutc_nxt;
  logic [8:0]        rowc_r, rowc_nxt;

  logic              accept;
  logic              cut_we, tbl_we, rq_we;
  logic [NP-1:0]     thr_we;
  logic [CAW-1:0]    cut_waddr, cut_raddr;
  logic [23:0]       cut_rdata;
  logic [7:0]        tbl_rdata, rq_rdata;
  logic [23:0]       thr_rdata [NP];
  logic [NW-1:0]     n_k;
  logic [5:0]        field_k;
  logic [RCW-1:0]    rows_lim;
  logic              row_ok;

  function automatic bqtl_pkg::q_t sat24(input logic signed [25:0] x);
    if (x > 26'sd8388607) begin
      return bqtl_pkg::Q_MAX;
    end else if (x < -26'sd8388608) begin
      return bqtl_pkg::Q_MIN;
    end
    return x[23:0];
  endfunction

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Store writes complete in the cycle the command is transferred.
  always_comb begin
    cut_we = 1'b0;
    tbl_we = 1'b0;
    rq_we  = 1'b0;
    thr_we = '0;
    if (accept) begin
      case (in_command)
        bqtl_pkg::CMD_WR_CUT:
          cut_we = (int'(in_column) < NP) && (int'(in_address) < MAX_CUTS);
        bqtl_pkg::CMD_WR_TABLE:
          tbl_we = int'(in_address) < TABLE_DEPTH;
        bqtl_pkg::CMD_WR_THRESH: begin
          for (int g = 0; g < NP; g++) begin
            thr_we[g] = (int'(in_column) == g) && (int'(in_address) < MAX_ROWS);
          end
        end
        bqtl_pkg::CMD_WR_RQUAL:
          rq_we = int'(in_address) < MAX_ROWS;
        default: ;
      endcase
    end
  end

  // The write enable already limits the slot to the cut store.
  assign cut_waddr = CAW'(int'(in_column) * MAX_CUTS + int'(in_address));
  assign cut_raddr = CAW'(int'(k_r) * MAX_CUTS + int'(j_r));

  bqtl_ram #(.WIDTH(24), .DEPTH(CD)) u_cut_ram (
    .clk(clk), .we(cut_we), .waddr(cut_waddr), .wdata(in_value),
    .raddr(cut_raddr), .rdata(cut_rdata)
  );

  bqtl_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_tbl_ram (
    .clk(clk), .we(tbl_we), .waddr(TAW'(in_address)), .wdata(in_value[7:0]),
    .raddr(a_r[TAW-1:0]), .rdata(tbl_rdata)
  );

  bqtl_ram #(.WIDTH(8), .DEPTH(MAX_ROWS)) u_rq_ram (
    .clk(clk), .we(rq_we), .waddr(RAW'(in_address)), .wdata(in_value[7:0]),
    .raddr(RAW'(r_r)), .rdata(rq_rdata)
  );

  for (genvar g = 0; g < NP; g++) begin : g_thr
    bqtl_ram #(.WIDTH(24), .DEPTH(MAX_ROWS)) u_thr_ram (
      .clk(clk), .we(thr_we[g]), .waddr(RAW'(in_address)), .wdata(in_value),
      .raddr(RAW'(r_r)), .rdata(thr_rdata[g])
    );
  end

  // Cut count of the predictor in hand, capped at MAX_CUTS.
  always_comb begin
    field_k = {1'b0, cutc_r[5*k_r +: 5]} + 6'd1;
    n_k = (int'(field_k) > MAX_CUTS) ? NW'(MAX_CUTS) : NW'(field_k);
  end

  assign rows_lim = (int'(rowc_r) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rowc_r);

  always_comb begin
    row_ok = 1'b1;
    for (int g = 0; g < NP; g++) begin
      if (p_r[g] > $signed(thr_rdata[g])) begin
        row_ok = 1'b0;
      end
    end
  end

  always_comb begin
    logic signed [25:0] x;
    logic signed [25:0] d;
    logic [NW-1:0]      idx_new;
    logic [NW-1:0]      idx_cap;
    logic [23:0]        div3;

    state_nxt       = state_r;
    prod_nxt        = prod_r;
    knee_nxt        = knee_r;
    k_nxt           = k_r;
    j_nxt           = j_r;
    idx_nxt         = idx_r;
    a_nxt           = a_r;
    r_nxt           = r_r;
    out_valid_nxt   = 1'b0;
    out_quality_nxt = out_quality_r;
    out_hit_nxt     = out_hit_r;
    mode_nxt        = mode_r;
    minq_nxt        = minq_r;
    cutc_nxt        = cutc_r;
    rowc_nxt        = rowc_r;
    for (int g = 0; g < NP; g++) begin
      p_nxt[g]      = p_r[g];
      colmax_nxt[g] = colmax_r[g];
    end
    x       = '0;
    d       = '0;
    idx_new = '0;
    idx_cap = '0;
    div3    = '0;

    if (cfg_we) begin
      case (cfg_index)
        bqtl_pkg::REG_MODE:      mode_nxt = cfg_data[0];
        bqtl_pkg::REG_MIN_QUAL:  minq_nxt = cfg_data[7:0];
        bqtl_pkg::REG_CUT_COUNT: cutc_nxt = cfg_data;
        bqtl_pkg::REG_ROW_COUNT: rowc_nxt = cfg_data[8:0];
        default: ;
      endcase
    end

    for (int g = 0; g < NP; g++) begin
      if (thr_we[g] && (in_value > colmax_r[g])) begin
        colmax_nxt[g] = in_value;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == bqtl_pkg::CMD_LOOKUP)) begin
          p_nxt[0]  = in_pred_0;
          p_nxt[1]  = in_pred_1;
          p_nxt[2]  = in_pred_2;
          p_nxt[3]  = in_pred_3;
          p_nxt[4]  = in_pred_4;
          p_nxt[5]  = in_pred_5;
          state_nxt = ST_FOLD_A;
        end
      end
      ST_FOLD_A: begin
        x = 26'(p_r[0]);
        if (x < 26'sd655) begin
          x = 26'(2 * bqtl_pkg::PEAK_P0) - x;
        end
        p_nxt[0] = sat24(x);
        x = -26'(p_r[5]);
        if (x < 26'(bqtl_pkg::PEAK_P5)) begin
          x = 26'(2 * bqtl_pkg::PEAK_P5) - x;
        end
        p_nxt[5] = sat24(x);
        // Fold predictor 4 at its peak; the part above the knee is divided
        // by three with a reciprocal multiply.
        x = 26'(p_r[4]);
        if (x < 26'(bqtl_pkg::PEAK_P4)) begin
          x = 26'(2 * bqtl_pkg::PEAK_P4) - x;
        end
        d        = x - 26'(bqtl_pkg::KNEE_P4);
        knee_nxt = x > 26'(bqtl_pkg::KNEE_P4);
        p_nxt[4] = sat24(x);
        prod_nxt = d[23:0] * bqtl_pkg::RECIP3;
        state_nxt = ST_FOLD_B;
      end
      ST_FOLD_B: begin
        div3 = 24'(prod_r[47:25]);
        if (knee_r) begin
          p_nxt[4] = 24'(bqtl_pkg::KNEE_P4) + div3;
        end
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        k_nxt   = '0;
        j_nxt   = '0;
        idx_nxt = '0;
        a_nxt   = '0;
        r_nxt   = '0;
        if (mode_r) begin
          for (int g = 0; g < NP; g++) begin
            if (p_r[g] > colmax_r[g]) begin
              p_nxt[g] = colmax_r[g];
            end
          end
          if (rows_lim == '0) begin
            out_valid_nxt   = 1'b1;
            out_quality_nxt = minq_r;
            out_hit_nxt     = 1'b0;
            state_nxt       = ST_IDLE;
          end else begin
            state_nxt = ST_ROW_RD;
          end
        end else begin
          state_nxt = ST_CUT_RD;
        end
      end
      ST_CUT_RD: begin
        state_nxt = ST_CUT_CMP;
      end
      ST_CUT_CMP: begin
        idx_new = idx_r + NW'($signed(cut_rdata) < p_r[k_r]);
        if (NW'(j_r) == n_k - NW'(1)) begin
          idx_cap   = (idx_new > n_k - NW'(1)) ? n_k - NW'(1) : idx_new;
          a_nxt     = AW'(a_r * n_k) + AW'(idx_cap);
          idx_nxt   = '0;
          j_nxt     = '0;
          if (int'(k_r) == NP - 1) begin
            state_nxt = ST_TBL_RD;
          end else begin
            k_nxt     = k_r + 3'd1;
            state_nxt = ST_CUT_RD;
          end
        end else begin
          idx_nxt   = idx_new;
          j_nxt     = j_r + JW'(1);
          state_nxt = ST_CUT_RD;
        end
      end
      ST_TBL_RD: begin
        if (64'(a_r) < 64'(TABLE_DEPTH)) begin
          state_nxt = ST_TBL_OUT;
        end else begin
          out_valid_nxt   = 1'b1;
          out_quality_nxt = minq_r;
          out_hit_nxt     = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_TBL_OUT: begin
        out_valid_nxt   = 1'b1;
        out_quality_nxt = tbl_rdata;
        out_hit_nxt     = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_ROW_RD: begin
        state_nxt = ST_ROW_CMP;
      end
      ST_ROW_CMP: begin
        if (row_ok) begin
          out_valid_nxt   = 1'b1;
          out_quality_nxt = rq_rdata;
          out_hit_nxt     = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (r_r + RCW'(1) == rows_lim) begin
          out_valid_nxt   = 1'b1;
          out_quality_nxt = minq_r;
          out_hit_nxt     = 1'b0;
          state_nxt       = ST_IDLE;
        end else begin
          r_nxt     = r_r + RCW'(1);
          state_nxt = ST_ROW_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      minq_r      <= '0;
      cutc_r      <= bqtl_pkg::CUT_COUNT_RESET;
      rowc_r      <= '0;
      for (int g = 0; g < NP; g++) begin
        colmax_r[g] <= bqtl_pkg::Q_MIN;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      minq_r      <= minq_nxt;
      cutc_r      <= cutc_nxt;
      rowc_r      <= rowc_nxt;
      for (int g = 0; g < NP; g++) begin
        colmax_r[g] <= colmax_nxt[g];
      end
    end
    for (int g = 0; g < NP; g++) begin
      p_r[g] <= p_nxt[g];
    end
    prod_r        <= prod_nxt;
    knee_r        <= knee_nxt;
    k_r           <= k_nxt;
    j_r           <= j_nxt;
    idx_r         <= idx_nxt;
    a_r           <= a_nxt;
    r_r           <= r_nxt;
    out_quality_r <= out_quality_nxt;
    out_hit_r     <= out_hit_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_quality = out_quality_r;
  assign out_hit     = out_hit_r;

endmodule
